// ----- design/ihp_pkg.sv -----
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types, widths and codes of the indexed min-heap.
// ----------------------------------------------------------------------------
`default_nettype none
package ihp_pkg;

  localparam int unsigned KEY_W        = 32;
  localparam int unsigned HANDLE_W     = 12;
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned HEAP_DEPTH_D = 1024;
  localparam int unsigned HANDLE_SP_D  = 4096;

  localparam logic [REQ_W-1:0] REQ_PUSH     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EXTRACT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DECREASE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NOP      = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MIN   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DROP  = 2'd3;

  typedef enum logic [4:0] {
    DP_IDLE,
    DP_START,
    DP_PUSH,
    DP_DROP,
    DP_EMPTY,
    DP_RD_POS,
    DP_RD_SLOT,
    DP_DEC_LOAD,
    DP_RD_ROOT,
    DP_RD_LAST,
    DP_EX_LOAD,
    DP_RD_PARENT,
    DP_UP_MOVE,
    DP_PLACE,
    DP_RD_LEFT,
    DP_RD_RIGHT,
    DP_DN_MOVE,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             push_ok;
    logic             empty;
    logic             tgt_ok;
    logic             dec_live;
    logic             at_root;
    logic             up_less;
    logic             last_is_root;
    logic             has_left;
    logic             down_less;
    logic             out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- design/ihp_if.sv -----
// ----------------------------------------------------------------------------
// ihp_req_if / ihp_rsp_if
// Request and response channels of the indexed min-heap.
// ----------------------------------------------------------------------------
`default_nettype none
interface ihp_req_if;
  import ihp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [KEY_W-1:0]  key_value;
  logic [HANDLE_W-1:0]      target_handle;
  modport source (output valid, req_type, key_value, target_handle, input ready);
  modport sink   (input valid, req_type, key_value, target_handle, output ready);
endinterface

interface ihp_rsp_if;
  import ihp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [KEY_W-1:0]  min_key;
  logic [HANDLE_W-1:0]      min_handle;
  modport source (output valid, status, min_key, min_handle, input ready);
  modport sink   (input valid, status, min_key, min_handle, output ready);
endinterface
`default_nettype wire

// ----- design/ihp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ihp_ctrl
// Sequencer: steps the datapath through push, extract and decrease.
// ----------------------------------------------------------------------------
`default_nettype none
module ihp_ctrl
  import ihp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_UP_RD, S_UP_CMP, S_DEC_SLOT, S_DEC_CHK,
    S_EX_LAST, S_EX_LOAD, S_DN_L, S_DN_R, S_DN_CMP, S_RESULT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o.op = DP_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_START;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.req_type)
          REQ_PUSH: begin
            if (stat_i.push_ok) begin
              cmd_o.op = DP_PUSH;
              state_d  = S_UP_RD;
            end else begin
              cmd_o.op = DP_DROP;
              state_d  = S_RESULT;
            end
          end
          REQ_EXTRACT: begin
            if (stat_i.empty) begin
              cmd_o.op = DP_EMPTY;
              state_d  = S_RESULT;
            end else begin
              cmd_o.op = DP_RD_ROOT;
              state_d  = S_EX_LAST;
            end
          end
          REQ_DECREASE: begin
            if (stat_i.tgt_ok) begin
              cmd_o.op = DP_RD_POS;
              state_d  = S_DEC_SLOT;
            end else begin
              state_d = S_RESULT;
            end
          end
          default: state_d = S_RESULT;
        endcase
      end
      S_UP_RD: begin
        if (stat_i.at_root) begin
          cmd_o.op = DP_PLACE;
          state_d  = S_RESULT;
        end else begin
          cmd_o.op = DP_RD_PARENT;
          state_d  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_less) begin
          cmd_o.op = DP_UP_MOVE;
          state_d  = S_UP_RD;
        end else begin
          cmd_o.op = DP_PLACE;
          state_d  = S_RESULT;
        end
      end
      S_DEC_SLOT: begin
        cmd_o.op = DP_RD_SLOT;
        state_d  = S_DEC_CHK;
      end
      S_DEC_CHK: begin
        if (stat_i.dec_live) begin
          cmd_o.op = DP_DEC_LOAD;
          state_d  = S_UP_RD;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_EX_LAST: begin
        cmd_o.op = DP_RD_LAST;
        state_d  = S_EX_LOAD;
      end
      S_EX_LOAD: begin
        cmd_o.op = DP_EX_LOAD;
        state_d  = stat_i.last_is_root ? S_RESULT : S_DN_L;
      end
      S_DN_L: begin
        if (stat_i.has_left) begin
          cmd_o.op = DP_RD_LEFT;
          state_d  = S_DN_R;
        end else begin
          cmd_o.op = DP_PLACE;
          state_d  = S_RESULT;
        end
      end
      S_DN_R: begin
        cmd_o.op = DP_RD_RIGHT;
        state_d  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.down_less) begin
          cmd_o.op = DP_DN_MOVE;
          state_d  = S_DN_L;
        end else begin
          cmd_o.op = DP_PLACE;
          state_d  = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = DP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/ihp_dp.sv -----
// ----------------------------------------------------------------------------
// ihp_dp
// Datapath: heap and position memories, moving entry, counters, result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module ihp_dp
  import ihp_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH   = HEAP_DEPTH_D,
  parameter int unsigned HANDLE_SPACE = HANDLE_SP_D
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire dp_cmd_t                 cmd_i,
  output dp_stat_t                     stat_o,
  input  wire logic [REQ_W-1:0]        req_type_i,
  input  wire logic signed [KEY_W-1:0] key_value_i,
  input  wire logic [HANDLE_W-1:0]     target_handle_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic signed [KEY_W-1:0]      min_key_o,
  output logic [HANDLE_W-1:0]          min_handle_o
);

  localparam int unsigned SW  = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned IW  = SW + 2;
  localparam int unsigned HIW = (HANDLE_SPACE > 1) ? $clog2(HANDLE_SPACE) : 1;
  localparam int unsigned OW  = $clog2(HANDLE_SPACE + 1);

  logic signed [KEY_W-1:0] key_mem [HEAP_DEPTH];
  logic [HIW-1:0]          hnd_mem [HEAP_DEPTH];
  logic [SW-1:0]           pos_mem [HANDLE_SPACE];

  logic [REQ_W-1:0]        req_q;
  logic signed [KEY_W-1:0] key_q;
  logic [HANDLE_W-1:0]     tgt_q;
  logic [OW-1:0]           opn_q;
  logic [OW-1:0]           op_cnt_q;
  logic [CW-1:0]           count_q;
  logic [SW-1:0]           idx_q;
  logic signed [KEY_W-1:0] ek_q, lk_q, rd_k_q;
  logic [HIW-1:0]          eh_q, lh_q, rd_h_q;
  logic [SW-1:0]           pos_q;
  logic [STATUS_W-1:0]     res_status_q;
  logic signed [KEY_W-1:0] res_key_q;
  logic [HANDLE_W-1:0]     res_handle_q;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic signed [KEY_W-1:0] out_key_q;
  logic [HANDLE_W-1:0]     out_handle_q;

  logic [IW-1:0]           wide_idx, left_w, right_w, count_w;
  logic [SW-1:0]           parent;
  logic                    has_right, use_right;
  logic signed [KEY_W-1:0] child_k;
  logic [HIW-1:0]          child_h;
  logic [SW-1:0]           child_idx;
  logic                    tgt_ok;

  logic                    hre, hwe, pwe;
  logic [SW-1:0]           hra, hwa;
  logic signed [KEY_W-1:0] hwk;
  logic [HIW-1:0]          hwh, pwa;
  logic [SW-1:0]           pwd;

  assign wide_idx  = IW'(idx_q);
  assign parent    = SW'((wide_idx - IW'(1)) >> 1);
  assign left_w    = IW'({idx_q, 1'b1});
  assign right_w   = left_w + IW'(1);
  assign count_w   = IW'(count_q);
  assign has_right = right_w < count_w;
  assign use_right = has_right && (rd_k_q < lk_q);
  assign child_k   = use_right ? rd_k_q : lk_q;
  assign child_h   = use_right ? rd_h_q : lh_q;
  assign child_idx = use_right ? SW'(right_w) : SW'(left_w);
  assign tgt_ok    = 32'(tgt_q) < 32'(HANDLE_SPACE);

  always_comb begin
    stat_o.req_type     = req_q;
    stat_o.push_ok      = (count_q < CW'(HEAP_DEPTH)) && (opn_q < OW'(HANDLE_SPACE));
    stat_o.empty        = (count_q == '0);
    stat_o.tgt_ok       = tgt_ok;
    stat_o.dec_live     = (CW'(pos_q) < count_q) && (rd_h_q == HIW'(tgt_q));
    stat_o.at_root      = (idx_q == '0);
    stat_o.up_less      = ek_q < rd_k_q;
    stat_o.last_is_root = (count_q == CW'(1));
    stat_o.has_left     = left_w < count_w;
    stat_o.down_less    = child_k < ek_q;
    stat_o.out_busy     = out_valid_q && !out_ready_i;
  end

  always_comb begin
    hre = 1'b1;
    hra = '0;
    hwe = 1'b0;
    hwa = idx_q;
    hwk = ek_q;
    hwh = eh_q;
    pwe = 1'b0;
    pwa = eh_q;
    pwd = idx_q;
    case (cmd_i.op)
      DP_RD_SLOT:   hra = pos_q;
      DP_RD_ROOT:   hra = '0;
      DP_RD_LAST:   hra = SW'(count_q - CW'(1));
      DP_RD_PARENT: hra = parent;
      DP_RD_LEFT:   hra = SW'(left_w);
      DP_RD_RIGHT:  hra = SW'(right_w);
      DP_UP_MOVE: begin
        hre = 1'b0;
        hwe = 1'b1;
        hwk = rd_k_q;
        hwh = rd_h_q;
        pwe = 1'b1;
        pwa = rd_h_q;
      end
      DP_DN_MOVE: begin
        hre = 1'b0;
        hwe = 1'b1;
        hwk = child_k;
        hwh = child_h;
        pwe = 1'b1;
        pwa = child_h;
      end
      DP_PLACE: begin
        hre = 1'b0;
        hwe = 1'b1;
        pwe = 1'b1;
      end
      default: hre = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hwe) begin
      key_mem[hwa] <= hwk;
      hnd_mem[hwa] <= hwh;
    end
    if (hre) begin
      rd_k_q <= key_mem[hra];
      rd_h_q <= hnd_mem[hra];
    end
    if (pwe) begin
      pos_mem[pwa] <= pwd;
    end
    if (cmd_i.op == DP_RD_POS) begin
      pos_q <= pos_mem[HIW'(tgt_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_cnt_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == DP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        DP_START: begin
          if (op_cnt_q < OW'(HANDLE_SPACE)) begin
            op_cnt_q <= op_cnt_q + OW'(1);
          end
        end
        DP_PUSH:    count_q <= count_q + CW'(1);
        DP_EX_LOAD: count_q <= count_q - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_START: begin
        req_q        <= req_type_i;
        key_q        <= key_value_i;
        tgt_q        <= target_handle_i;
        opn_q        <= op_cnt_q;
        res_status_q <= ST_DONE;
        res_key_q    <= '0;
        res_handle_q <= '0;
      end
      DP_PUSH: begin
        ek_q  <= key_q;
        eh_q  <= HIW'(opn_q);
        idx_q <= SW'(count_q);
      end
      DP_DROP:  res_status_q <= ST_DROP;
      DP_EMPTY: res_status_q <= ST_EMPTY;
      DP_RD_SLOT: idx_q <= pos_q;
      DP_DEC_LOAD: begin
        ek_q <= (key_q < rd_k_q) ? key_q : rd_k_q;
        eh_q <= HIW'(tgt_q);
      end
      DP_RD_LAST: begin
        res_status_q <= ST_MIN;
        res_key_q    <= rd_k_q;
        res_handle_q <= HANDLE_W'(rd_h_q);
      end
      DP_EX_LOAD: begin
        ek_q  <= rd_k_q;
        eh_q  <= rd_h_q;
        idx_q <= '0;
      end
      DP_UP_MOVE: idx_q <= parent;
      DP_RD_RIGHT: begin
        lk_q <= rd_k_q;
        lh_q <= rd_h_q;
      end
      DP_DN_MOVE: idx_q <= child_idx;
      DP_RESULT: begin
        out_status_q <= res_status_q;
        out_key_q    <= res_key_q;
        out_handle_q <= res_handle_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign min_key_o    = out_key_q;
  assign min_handle_o = out_handle_q;

endmodule
`default_nettype wire

// ----- design/indexed_min_heap.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap
// Binary min-heap of signed keys with handles and decrease-key.
// ----------------------------------------------------------------------------
// One request is taken at a time; a finished response waits in an output
// register while the next request is accepted. The heap array is a single
// memory with one read and one write per cycle, so each sift level going up
// takes a parent read and then a compare/move step, and each level going
// down takes a left-child read, a right-child read, then a compare/move step.
// The position memory needs no clearing after reset: a handle counts as live
// only when its recorded slot lies inside the heap and holds that handle.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_min_heap
  import ihp_pkg::*;
#(
  parameter int unsigned HEAP_DEPTH   = HEAP_DEPTH_D,
  parameter int unsigned HANDLE_SPACE = HANDLE_SP_D
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ihp_req_if.sink     req_i,
  ihp_rsp_if.source   rsp_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ihp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ihp_dp #(
    .HEAP_DEPTH   (HEAP_DEPTH),
    .HANDLE_SPACE (HANDLE_SPACE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_type_i      (req_i.req_type),
    .key_value_i     (req_i.key_value),
    .target_handle_i (req_i.target_handle),
    .out_valid_o     (rsp_o.valid),
    .out_ready_i     (rsp_o.ready),
    .status_o        (rsp_o.status),
    .min_key_o       (rsp_o.min_key),
    .min_handle_o    (rsp_o.min_handle)
  );

endmodule
`default_nettype wire

// ----- design/ihp_checker.sv -----
// ----------------------------------------------------------------------------
// ihp_checker
// Port-level checks of the indexed min-heap, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module ihp_checker
  import ihp_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [STATUS_W-1:0]     status,
  input wire logic signed [KEY_W-1:0] min_key,
  input wire logic [HANDLE_W-1:0]     min_handle
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(min_key)
      && $stable(min_handle))
    else $error("response beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (status != ST_MIN) |-> (min_key == '0) && (min_handle == '0))
    else $error("non-minimum response carries key or handle");

  a_no_result_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("response appeared in the cycle after acceptance");

endmodule

bind indexed_min_heap ihp_checker u_ihp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req_i.valid),
  .in_ready   (req_i.ready),
  .out_valid  (rsp_o.valid),
  .out_ready  (rsp_o.ready),
  .status     (rsp_o.status),
  .min_key    (rsp_o.min_key),
  .min_handle (rsp_o.min_handle)
);
`default_nettype wire
